/* sv/lj_pkg.sv */
// shared types, constants and arithmetic helpers of the lennard-jones pair kernel
package lj_pkg;

    localparam int IN_WIDTH     = 32;
    localparam int IN_FRAC_BITS = 16;
    localparam int OUT_WIDTH    = 48;
    localparam int OUT_FRAC     = OUT_WIDTH / 2;
    localparam int EPS_WIDTH    = 32;
    localparam int EPS24_WIDTH  = EPS_WIDTH + 5;
    localparam int E_SHIFT      = IN_FRAC_BITS + 30 - OUT_FRAC;
    localparam int F_SHIFT      = 32 + IN_FRAC_BITS - OUT_FRAC;
    localparam int DIV_STEPS    = 64;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    // 2^(-1/3) as unsigned q0.32
    localparam logic [31:0] K_Q32 = 32'd3408917802;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd65536;
    localparam logic [OUT_WIDTH-2:0] OUT_MAXMAG = '1;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_FAR,
        KIND_ZERO_DIST,
        KIND_ZERO_EPS
    } lj_kind_t;

    typedef struct packed {
        lj_kind_t                   kind;
        logic [2:0]                 dneg;
        logic [2:0][IN_WIDTH-1:0]   dmag;
        logic [IN_WIDTH-1:0]        r;
        logic [IN_WIDTH-1:0]        c;
    } lj_req_t;

    typedef struct packed {
        lj_kind_t                   kind;
        logic [2:0]                 dneg;
        logic [2:0][IN_WIDTH-1:0]   dmag;
        logic [IN_WIDTH-1:0]        r;
        logic                       huge;
        logic                       tneg;
        logic                       eneg;
        logic [95:0]                eprod;
    } lj_ctx_t;

    typedef logic [3:0][63:0] lj_pp_t;

    function automatic lj_pp_t mul_pp(input logic [63:0] x, input logic [63:0] y);
        lj_pp_t pp;
        pp[0] = 64'(x[31:0]) * 64'(y[31:0]);
        pp[1] = 64'(x[31:0]) * 64'(y[63:32]);
        pp[2] = 64'(x[63:32]) * 64'(y[31:0]);
        pp[3] = 64'(x[63:32]) * 64'(y[63:32]);
        return pp;
    endfunction

    function automatic logic [127:0] pp_sum(input lj_pp_t pp);
        return {pp[3], 64'd0} + {32'd0, pp[1], 32'd0} + {32'd0, pp[2], 32'd0}
            + {64'd0, pp[0]};
    endfunction

    // q32 rescale, msb of the result is the overflow flag
    function automatic logic [64:0] shr32_sat(input logic [127:0] v);
        if (v[127:96] != 32'd0)
            return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        return {1'b0, v[95:32]};
    endfunction

    function automatic logic [OUT_WIDTH-1:0] encode(input logic neg,
                                                    input logic [OUT_WIDTH-2:0] mag);
        logic [OUT_WIDTH-1:0] m;
        m = {1'b0, mag};
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage

/* sv/lj_front.sv */
// front end: takes a request, splits displacement into sign and magnitude, classifies the pair
module lj_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic signed [lj_pkg::IN_WIDTH-1:0] disp_x,
    input  logic signed [lj_pkg::IN_WIDTH-1:0] disp_y,
    input  logic signed [lj_pkg::IN_WIDTH-1:0] disp_z,
    input  logic [lj_pkg::IN_WIDTH-1:0]     dist_squared,
    input  logic [lj_pkg::IN_WIDTH-1:0]     contact_squared,
    input  logic [lj_pkg::EPS_WIDTH-1:0]    eps,
    output logic                            req_valid,
    output lj_pkg::lj_req_t                 req
);
    import lj_pkg::*;

    logic                    valid_reg;
    lj_req_t                 req_reg;
    lj_req_t                 req_next;
    logic [2:0][IN_WIDTH-1:0] dv;
    logic [IN_WIDTH+4:0]     r4;
    logic [IN_WIDTH+4:0]     c25;

    assign dv[0] = disp_x;
    assign dv[1] = disp_y;
    assign dv[2] = disp_z;
    assign r4  = {3'b000, dist_squared, 2'b00};
    assign c25 = {5'b0, contact_squared} + {1'b0, contact_squared, 4'b0}
               + {2'b0, contact_squared, 3'b0};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            req_next.dneg[k] = dv[k][IN_WIDTH-1];
            req_next.dmag[k] = dv[k][IN_WIDTH-1] ? (~dv[k] + 1'b1) : dv[k];
        end
        req_next.r = dist_squared;
        req_next.c = contact_squared;
        if (r4 > c25)
            req_next.kind = KIND_FAR;
        else if (dist_squared == '0)
            req_next.kind = KIND_ZERO_DIST;
        else if (eps == '0)
            req_next.kind = KIND_ZERO_EPS;
        else
            req_next.kind = KIND_NORMAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req_next;
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

/* sv/lj_fifo.sv */
// short request queue between front and back end
module lj_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lj_pkg::lj_req_t push_data,
    input  logic            pop,
    output logic            not_empty,
    output lj_pkg::lj_req_t pop_data,
    output logic            almost_full
);
    import lj_pkg::*;

    lj_req_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 do_pop;

    assign not_empty   = (count_reg != '0);
    assign do_pop      = pop && not_empty;
    assign pop_data    = mem[rd_ptr_reg];
    assign almost_full = (count_reg >= FIFO_CW'(FIFO_DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* sv/lj_div.sv */
// pipelined restoring divider, one quotient bit per stage, divisor carried in the context
module lj_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [31:0]     in_rem,
    input  logic [63:0]     in_num,
    input  lj_pkg::lj_ctx_t in_ctx,
    output logic            out_valid,
    output logic [63:0]     out_quo,
    output lj_pkg::lj_ctx_t out_ctx
);
    import lj_pkg::*;

    logic        valid_reg [DIV_STEPS];
    logic [31:0] rem_reg   [DIV_STEPS];
    logic [63:0] num_reg   [DIV_STEPS];
    logic [63:0] quo_reg   [DIV_STEPS];
    lj_ctx_t     ctx_reg   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic        v_in;
        logic [31:0] rem_in;
        logic [63:0] num_in;
        logic [63:0] quo_in;
        lj_ctx_t     ctx_in;
        logic [32:0] rem_cat;
        logic [32:0] rem_sub;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = in_rem;
            assign num_in = in_num;
            assign quo_in = '0;
            assign ctx_in = in_ctx;
        end
        else
        begin : g_next
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign ctx_in = ctx_reg[k-1];
        end

        assign rem_cat = {rem_in, num_in[63]};
        assign ge      = (rem_cat >= {1'b0, ctx_in.r});
        assign rem_sub = rem_cat - {1'b0, ctx_in.r};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? rem_sub[31:0] : rem_cat[31:0];
            num_reg[k] <= {num_in[62:0], 1'b0};
            quo_reg[k] <= {quo_in[62:0], ge};
            ctx_reg[k] <= ctx_in;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_quo   = quo_reg[DIV_STEPS-1];
    assign out_ctx   = ctx_reg[DIV_STEPS-1];

endmodule

/* sv/lj_back.sv */
// back end: sigma ratio, powers, force factor and saturating result stage
module lj_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  lj_pkg::lj_req_t                    req,
    input  logic [lj_pkg::EPS_WIDTH-1:0]       eps,
    output logic                               done,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] pair_energy,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] force_x,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] force_y,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] force_z,
    output logic                               in_range,
    output logic                               clipped
);
    import lj_pkg::*;

    logic [EPS24_WIDTH-1:0] eps24;
    assign eps24 = {1'b0, eps, 4'b0} + {2'b0, eps, 3'b0};

    // c times k
    logic        v_b0_reg;
    lj_ctx_t     ctx_b0_reg;
    logic [63:0] p0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_b0_reg <= 1'b0;
        else
            v_b0_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        p0_reg           <= 64'(req.c) * 64'(K_Q32);
        ctx_b0_reg.kind  <= req.kind;
        ctx_b0_reg.dneg  <= req.dneg;
        ctx_b0_reg.dmag  <= req.dmag;
        ctx_b0_reg.r     <= req.r;
        ctx_b0_reg.huge  <= 1'b0;
        ctx_b0_reg.tneg  <= 1'b0;
        ctx_b0_reg.eneg  <= 1'b0;
        ctx_b0_reg.eprod <= '0;
    end

    // s = sigma^2 / r
    logic        v_s;
    logic [63:0] s_val;
    lj_ctx_t     ctx_s;

    lj_div u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_b0_reg),
        .in_rem    (32'd0),
        .in_num    (p0_reg),
        .in_ctx    (ctx_b0_reg),
        .out_valid (v_s),
        .out_quo   (s_val),
        .out_ctx   (ctx_s)
    );

    // power chain: s^2, s^3, s^6
    logic        v_m1a_reg, v_m1b_reg, v_m2a_reg, v_m2b_reg, v_m3a_reg, v_m3b_reg;
    lj_ctx_t     ctx_m1a_reg, ctx_m1b_reg, ctx_m2a_reg, ctx_m2b_reg, ctx_m3a_reg, ctx_m3b_reg;
    lj_ctx_t     ctx_m1b_next, ctx_m2b_next, ctx_m3b_next;
    lj_pp_t      pp1_reg, pp2_reg, pp3_reg;
    logic [63:0] s1_reg, s2_reg, a1_reg, a_reg, a3_reg, a4_reg, b_reg;
    logic [64:0] sq_sat, cube_sat, six_sat;

    assign sq_sat   = shr32_sat(pp_sum(pp1_reg));
    assign cube_sat = shr32_sat(pp_sum(pp2_reg));
    assign six_sat  = shr32_sat(pp_sum(pp3_reg));

    always_comb
    begin
        ctx_m1b_next      = ctx_m1a_reg;
        ctx_m1b_next.huge = ctx_m1a_reg.huge | sq_sat[64];
        ctx_m2b_next      = ctx_m2a_reg;
        ctx_m2b_next.huge = ctx_m2a_reg.huge | cube_sat[64];
        ctx_m3b_next      = ctx_m3a_reg;
        // b must stay below 2^62 so that 2b fits
        ctx_m3b_next.huge = ctx_m3a_reg.huge | six_sat[64] | six_sat[63] | six_sat[62];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_m1a_reg <= 1'b0;
            v_m1b_reg <= 1'b0;
            v_m2a_reg <= 1'b0;
            v_m2b_reg <= 1'b0;
            v_m3a_reg <= 1'b0;
            v_m3b_reg <= 1'b0;
        end
        else
        begin
            v_m1a_reg <= v_s;
            v_m1b_reg <= v_m1a_reg;
            v_m2a_reg <= v_m1b_reg;
            v_m2b_reg <= v_m2a_reg;
            v_m3a_reg <= v_m2b_reg;
            v_m3b_reg <= v_m3a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp1_reg     <= mul_pp(s_val, s_val);
        s1_reg      <= s_val;
        ctx_m1a_reg <= ctx_s;

        a1_reg      <= sq_sat[63:0];
        s2_reg      <= s1_reg;
        ctx_m1b_reg <= ctx_m1b_next;

        pp2_reg     <= mul_pp(a1_reg, s2_reg);
        ctx_m2a_reg <= ctx_m1b_reg;

        a_reg       <= cube_sat[63:0];
        ctx_m2b_reg <= ctx_m2b_next;

        pp3_reg     <= mul_pp(a_reg, a_reg);
        a3_reg      <= a_reg;
        ctx_m3a_reg <= ctx_m2b_reg;

        b_reg       <= six_sat[63:0];
        a4_reg      <= a3_reg;
        ctx_m3b_reg <= ctx_m3b_next;
    end

    // differences 2b - a and b - a
    logic        v_t_reg;
    lj_ctx_t     ctx_t_reg;
    lj_ctx_t     ctx_t_next;
    logic [63:0] tmag_reg, emag_reg;
    logic [63:0] two_b;
    logic        tneg_next, eneg_next;

    assign two_b     = {b_reg[62:0], 1'b0};
    assign tneg_next = (two_b < a4_reg);
    assign eneg_next = (b_reg < a4_reg);

    always_comb
    begin
        ctx_t_next      = ctx_m3b_reg;
        ctx_t_next.tneg = tneg_next;
        ctx_t_next.eneg = eneg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_t_reg <= 1'b0;
        else
            v_t_reg <= v_m3b_reg;
    end

    always_ff @(posedge clk)
    begin
        tmag_reg  <= tneg_next ? (a4_reg - two_b) : (two_b - a4_reg);
        emag_reg  <= eneg_next ? (a4_reg - b_reg) : (b_reg - a4_reg);
        ctx_t_reg <= ctx_t_next;
    end

    // 24 eps |2b - a| and eps |b - a|
    logic                        v_m4a_reg, v_m4b_reg;
    lj_ctx_t                     ctx_m4a_reg, ctx_m4b_reg;
    lj_ctx_t                     ctx_m4b_next;
    logic [EPS24_WIDTH+31:0]     tp_lo_reg, tp_hi_reg;
    logic [63:0]                 ep_lo_reg, ep_hi_reg;
    logic [31:0]                 drem_reg;
    logic [63:0]                 dnum_reg;
    logic [EPS24_WIDTH+63:0]     tprod;
    logic [95:0]                 eprod;

    assign tprod = ((EPS24_WIDTH+64)'(tp_hi_reg) << 32) + (EPS24_WIDTH+64)'(tp_lo_reg);
    assign eprod = (96'(ep_hi_reg) << 32) + 96'(ep_lo_reg);

    always_comb
    begin
        ctx_m4b_next       = ctx_m4a_reg;
        ctx_m4b_next.eprod = eprod;
        // quotient would not fit 64 bits
        ctx_m4b_next.huge  = ctx_m4a_reg.huge
                           | (tprod[EPS24_WIDTH+63:64] >= EPS24_WIDTH'(ctx_m4a_reg.r));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_m4a_reg <= 1'b0;
            v_m4b_reg <= 1'b0;
        end
        else
        begin
            v_m4a_reg <= v_t_reg;
            v_m4b_reg <= v_m4a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tp_lo_reg   <= (EPS24_WIDTH+32)'(eps24) * (EPS24_WIDTH+32)'(tmag_reg[31:0]);
        tp_hi_reg   <= (EPS24_WIDTH+32)'(eps24) * (EPS24_WIDTH+32)'(tmag_reg[63:32]);
        ep_lo_reg   <= 64'(eps) * 64'(emag_reg[31:0]);
        ep_hi_reg   <= 64'(eps) * 64'(emag_reg[63:32]);
        ctx_m4a_reg <= ctx_t_reg;

        drem_reg    <= tprod[95:64];
        dnum_reg    <= tprod[63:0];
        ctx_m4b_reg <= ctx_m4b_next;
    end

    // g = 24 eps |2b - a| / r
    logic        v_g;
    logic [63:0] g_val;
    lj_ctx_t     ctx_g;

    lj_div u_div_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_m4b_reg),
        .in_rem    (drem_reg),
        .in_num    (dnum_reg),
        .in_ctx    (ctx_m4b_reg),
        .out_valid (v_g),
        .out_quo   (g_val),
        .out_ctx   (ctx_g)
    );

    // force partial products
    logic               v_m5a_reg;
    lj_ctx_t            ctx_m5a_reg;
    logic [2:0][63:0]   fp_lo_reg, fp_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_m5a_reg <= 1'b0;
        else
            v_m5a_reg <= v_g;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            fp_lo_reg[k] <= 64'(g_val[31:0]) * 64'(ctx_g.dmag[k]);
            fp_hi_reg[k] <= 64'(g_val[63:32]) * 64'(ctx_g.dmag[k]);
        end
        ctx_m5a_reg <= ctx_g;
    end

    // rescale, saturate and pick the result by pair class
    logic                         done_reg, in_range_reg, clipped_reg;
    logic [OUT_WIDTH-1:0]         energy_reg;
    logic [2:0][OUT_WIDTH-1:0]    force_reg;
    logic                         in_range_next, clipped_next;
    logic [OUT_WIDTH-1:0]         energy_next;
    logic [2:0][OUT_WIDTH-1:0]    force_next;
    logic [95:0]                  fprod;
    logic                         fclip_any, eclip;
    logic [OUT_WIDTH-2:0]         fm, em;
    logic [2:0][OUT_WIDTH-1:0]    fval, fsat;

    always_comb
    begin
        fclip_any = 1'b0;
        fprod     = '0;
        fm        = '0;
        for (int k = 0; k < 3; k++)
        begin
            fprod = (96'(fp_hi_reg[k]) << 32) + 96'(fp_lo_reg[k]);
            if (fprod[95:F_SHIFT+OUT_WIDTH-1] != '0)
            begin
                fm        = OUT_MAXMAG;
                fclip_any = 1'b1;
            end
            else
                fm = fprod[F_SHIFT+OUT_WIDTH-2:F_SHIFT];
            fval[k] = encode(ctx_m5a_reg.tneg ? ctx_m5a_reg.dneg[k] : ~ctx_m5a_reg.dneg[k], fm);
            fsat[k] = (ctx_m5a_reg.dmag[k] != '0) ? encode(~ctx_m5a_reg.dneg[k], OUT_MAXMAG)
                                                  : '0;
        end
        eclip = (ctx_m5a_reg.eprod[95:E_SHIFT+OUT_WIDTH-1] != '0);
        em    = eclip ? OUT_MAXMAG : ctx_m5a_reg.eprod[E_SHIFT+OUT_WIDTH-2:E_SHIFT];

        in_range_next = 1'b1;
        clipped_next  = 1'b0;
        energy_next   = '0;
        force_next    = '0;
        unique case (ctx_m5a_reg.kind)
            KIND_FAR:
            begin
                in_range_next = 1'b0;
            end
            KIND_ZERO_DIST:
            begin
                energy_next  = {1'b0, OUT_MAXMAG};
                clipped_next = 1'b1;
            end
            KIND_ZERO_EPS:
            begin
                energy_next = '0;
            end
            KIND_NORMAL:
            begin
                if (ctx_m5a_reg.huge)
                begin
                    energy_next  = {1'b0, OUT_MAXMAG};
                    force_next   = fsat;
                    clipped_next = 1'b1;
                end
                else
                begin
                    energy_next  = encode(ctx_m5a_reg.eneg, em);
                    force_next   = fval;
                    clipped_next = eclip | fclip_any;
                end
            end
            default:
            begin
                in_range_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_m5a_reg;
    end

    always_ff @(posedge clk)
    begin
        energy_reg   <= energy_next;
        force_reg    <= force_next;
        in_range_reg <= in_range_next;
        clipped_reg  <= clipped_next;
    end

    assign done        = done_reg;
    assign pair_energy = energy_reg;
    assign force_x     = force_reg[0];
    assign force_y     = force_reg[1];
    assign force_z     = force_reg[2];
    assign in_range    = in_range_reg;
    assign clipped     = clipped_reg;

endmodule

/* sv/lj_pair_force_energy_top.sv */
// top level of the lennard-jones 12-6 pair force and energy kernel
// usage:
//   a request is taken at a rising edge with start high and busy low; it carries the
//   pair displacement (signed q16.16), squared distance and squared radii sum
//   (unsigned q16.16).
//   each result shows on the result ports for one cycle with done high: energy and
//   force in signed q24.24, in_range and clipped flags. results leave in request order.
//   the receiver cannot stall; the pipeline never holds, so busy stays low in use.
//   on its way each request passes the front register, the queue, two 64-stage
//   pipelined restoring dividers (sigma^2/r and the force factor) and the
//   partial-product multiplier stages between them.
//   throughput: one request per cycle, back to back, while busy is low.
//   well depth is written through cfg_write/cfg_wdata (unsigned q16.16) while no
//   request is in flight.
// reset:
//   rst_n clears the pipeline and queue and sets well depth to 1.0; no result
//   appears until a request is taken.
module lj_pair_force_energy_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lj_pkg::IN_WIDTH-1:0]  disp_x,
    input  logic signed [lj_pkg::IN_WIDTH-1:0]  disp_y,
    input  logic signed [lj_pkg::IN_WIDTH-1:0]  disp_z,
    input  logic [lj_pkg::IN_WIDTH-1:0]         dist_squared,
    input  logic [lj_pkg::IN_WIDTH-1:0]         contact_squared,
    input  logic                                cfg_write,
    input  logic [lj_pkg::EPS_WIDTH-1:0]        cfg_wdata,
    output logic                                done,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] pair_energy,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] force_x,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] force_y,
    output logic signed [lj_pkg::OUT_WIDTH-1:0] force_z,
    output logic                                in_range,
    output logic                                clipped
);
    import lj_pkg::*;

    logic [EPS_WIDTH-1:0] well_depth_reg;
    logic                 accept;
    logic                 front_valid;
    lj_req_t              front_req;
    logic                 q_valid;
    lj_req_t              q_req;
    logic                 q_almost_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            well_depth_reg <= EPS_RESET;
        else if (cfg_write)
            well_depth_reg <= cfg_wdata;
    end

    assign busy   = q_almost_full;
    assign accept = start && !busy;

    lj_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .disp_x          (disp_x),
        .disp_y          (disp_y),
        .disp_z          (disp_z),
        .dist_squared    (dist_squared),
        .contact_squared (contact_squared),
        .eps             (well_depth_reg),
        .req_valid       (front_valid),
        .req             (front_req)
    );

    lj_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (front_valid),
        .push_data   (front_req),
        .pop         (1'b1),
        .not_empty   (q_valid),
        .pop_data    (q_req),
        .almost_full (q_almost_full)
    );

    lj_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (q_valid),
        .req         (q_req),
        .eps         (well_depth_reg),
        .done        (done),
        .pair_energy (pair_energy),
        .force_x     (force_x),
        .force_y     (force_y),
        .force_z     (force_z),
        .in_range    (in_range),
        .clipped     (clipped)
    );

    // a pair beyond the cutoff gives nothing at all
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_range |-> pair_energy == '0 && force_x == '0 && force_y == '0
            && force_z == '0 && !clipped)
        else $error("out-of-range pair with nonzero result");

    // a clipped result always belongs to an in-range pair
    assert property (@(posedge clk) disable iff (!rst_n)
        done && clipped |-> in_range)
        else $error("clipped flag on an out-of-range pair");

    // an accepted request reaches the front register in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> front_valid)
        else $error("accepted request lost in front end");

endmodule
